// File: design/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// Shared constants and types for the histogram binning accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hba_pkg;

    localparam int MAX_BINS    = 64;
    localparam int MIN_BINS    = 4;
    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 32;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int NBINS_W     = BIN_W + 1;
    localparam int SHIFT_W     = 5;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int IN_RAW_W    = SAMPLE_BITS + BIN_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = BIN_W + COUNT_BITS + 2 * SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SHIFT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = CFG_IDX_W'(3);

    localparam logic [NBINS_W-1:0] BIN_COUNT_RST = NBINS_W'(MAX_BINS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

endpackage

`default_nettype wire

// File: design/histogram_binning_accumulator.sv
// ----------------------------------------------------------------------------
// histogram_binning_accumulator
// Counts signed samples into uniform bins with open-ended first and last bins,
// tracks extreme values seen in the end bins, and serves read/clear requests.
//
//  channel   direction  handshake                  payload
//  s stream  in         i_s_tvalid / o_s_tready    tdata {read_index, sample}, tuser command
//  m stream  out        o_m_tvalid / i_m_tready    tdata {max, min, value, index}
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request per cycle while the m side is not stalled; results pass three
// register stages: input register, bin ram read, output register
// the bin ram is read from the input stage and written back from the read stage;
// a same-bin request right behind another gets the count forwarded from the write-back
// per-bin valid flops clear at reset and on a clear request, no sweep
// a stall on the m side holds the whole pipeline and drops o_s_tready
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_binning_accumulator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // sample[31:0], read_index[37:32], zero pad
    input  wire logic [hba_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // command[1:0]
    input  wire logic [hba_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // bin_index[5:0], bin_value[37:6], seen_min[69:38], seen_max[101:70], pad
    output logic [hba_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hba_pkg::*;

    // configuration
    logic signed [SAMPLE_BITS-1:0] r_low_edge;
    logic signed [SAMPLE_BITS-1:0] r_high_edge;
    logic        [SHIFT_W-1:0]     r_bin_shift;
    logic        [NBINS_W-1:0]     r_bin_count;

    // tracked extremes
    logic signed [SAMPLE_BITS-1:0] r_seen_min;
    logic signed [SAMPLE_BITS-1:0] r_seen_max;
    logic signed [SAMPLE_BITS-1:0] n_seen_min;
    logic signed [SAMPLE_BITS-1:0] n_seen_max;

    // input stage
    logic                          r_a_vld;
    t_cmd                          r_a_cmd;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic        [BIN_W-1:0]       r_a_ridx;

    // ram read stage
    logic                          r_b_vld;
    t_cmd                          r_b_cmd;
    logic        [BIN_W-1:0]       r_b_idx;
    logic signed [SAMPLE_BITS-1:0] r_b_min;
    logic signed [SAMPLE_BITS-1:0] r_b_max;
    logic        [COUNT_BITS-1:0]  r_rd;

    // write-back forward
    logic                          r_w_vld;
    logic        [BIN_W-1:0]       r_w_idx;
    logic        [COUNT_BITS-1:0]  r_w_val;

    // output stage
    logic                          r_o_vld;
    t_cmd                          r_o_cmd;
    logic        [BIN_W-1:0]       r_o_idx;
    logic        [COUNT_BITS-1:0]  r_o_val;
    logic signed [SAMPLE_BITS-1:0] r_o_min;
    logic signed [SAMPLE_BITS-1:0] r_o_max;

    // bin storage
    logic [COUNT_BITS-1:0] r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]   r_valid;

    logic                   adv;
    logic                   s_acc;
    logic [NBINS_W-1:0]     nbins;
    logic [NBINS_W-1:0]     mid_max;
    logic                   a_lt_low;
    logic                   a_lt_high;
    logic [SAMPLE_BITS-1:0] a_diff;
    logic [SAMPLE_BITS-1:0] a_q;
    logic [BIN_W-1:0]       a_bin;
    logic [BIN_W-1:0]       a_idx;
    logic [COUNT_BITS-1:0]  b_base;
    logic [COUNT_BITS-1:0]  b_inc;
    logic                   b_wr;
    logic [BIN_W-1:0]       b_out_idx;
    logic [COUNT_BITS-1:0]  b_out_val;

    assign adv         = !r_o_vld || i_m_tready;
    assign o_s_tready  = adv;
    assign s_acc       = i_s_tvalid && adv;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_edge  <= '0;
            r_high_edge <= '0;
            r_bin_shift <= '0;
            r_bin_count <= BIN_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_EDGE:  r_low_edge  <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_HIGH_EDGE: r_high_edge <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_BIN_SHIFT: r_bin_shift <= i_cfg_data[SHIFT_W-1:0];
                REG_BIN_COUNT: r_bin_count <= i_cfg_data[NBINS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // bin index
    always_comb begin
        if (r_bin_count < NBINS_W'(MIN_BINS)) begin
            nbins = NBINS_W'(MIN_BINS);
        end else if (r_bin_count > NBINS_W'(MAX_BINS)) begin
            nbins = NBINS_W'(MAX_BINS);
        end else begin
            nbins = r_bin_count;
        end
        mid_max   = nbins - NBINS_W'(3);
        a_lt_low  = r_a_sample < r_low_edge;
        a_lt_high = r_a_sample < r_high_edge;
        a_diff    = r_a_sample - r_low_edge;
        a_q       = a_diff >> r_bin_shift;
        if (a_lt_low) begin
            a_bin = '0;
        end else if (!a_lt_high) begin
            a_bin = BIN_W'(nbins - NBINS_W'(1));
        end else if (a_q > SAMPLE_BITS'(mid_max)) begin
            a_bin = BIN_W'(mid_max) + BIN_W'(1);
        end else begin
            a_bin = a_q[BIN_W-1:0] + BIN_W'(1);
        end
        case (r_a_cmd)
            CMD_ADD:  a_idx = a_bin;
            CMD_READ: a_idx = r_a_ridx;
            default:  a_idx = '0;
        endcase
    end

    // extremes
    always_comb begin
        n_seen_min = r_seen_min;
        n_seen_max = r_seen_max;
        if (r_a_vld) begin
            case (r_a_cmd)
                CMD_ADD: begin
                    if (a_lt_low) begin
                        if (r_a_sample < r_seen_min) begin
                            n_seen_min = r_a_sample;
                        end
                    end else if (!a_lt_high) begin
                        if (r_a_sample > r_seen_max) begin
                            n_seen_max = r_a_sample;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_seen_min = r_low_edge;
                    n_seen_max = r_high_edge;
                end
                default: begin
                end
            endcase
        end
    end

    // count update
    always_comb begin
        if (r_w_vld && (r_w_idx == r_b_idx)) begin
            b_base = r_w_val;
        end else if (r_valid[r_b_idx]) begin
            b_base = r_rd;
        end else begin
            b_base = '0;
        end
        b_inc     = (&b_base) ? b_base : b_base + COUNT_BITS'(1);
        b_wr      = r_b_vld && (r_b_cmd == CMD_ADD);
        b_out_idx = r_b_idx;
        case (r_b_cmd)
            CMD_ADD:  b_out_val = b_inc;
            CMD_READ: b_out_val = b_base;
            default:  b_out_val = '0;
        endcase
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
            r_w_vld    <= 1'b0;
            r_valid    <= '0;
            r_seen_min <= '0;
            r_seen_max <= '0;
        end else if (adv) begin
            r_a_vld    <= i_s_tvalid;
            r_b_vld    <= r_a_vld;
            r_o_vld    <= r_b_vld;
            r_w_vld    <= b_wr;
            r_seen_min <= n_seen_min;
            r_seen_max <= n_seen_max;
            if (r_b_vld && (r_b_cmd == CMD_CLEAR)) begin
                r_valid <= '0;
            end else if (b_wr) begin
                r_valid[r_b_idx] <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_cmd    <= t_cmd'(i_s_tuser);
            r_a_sample <= i_s_tdata[SAMPLE_BITS-1:0];
            r_a_ridx   <= i_s_tdata[SAMPLE_BITS +: BIN_W];
        end
        if (adv) begin
            r_b_cmd <= r_a_cmd;
            r_b_idx <= a_idx;
            r_b_min <= n_seen_min;
            r_b_max <= n_seen_max;
            r_w_idx <= r_b_idx;
            r_w_val <= b_inc;
            r_o_cmd <= r_b_cmd;
            r_o_idx <= b_out_idx;
            r_o_val <= b_out_val;
            r_o_min <= r_b_min;
            r_o_max <= r_b_max;
        end
    end

    // bin ram
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd <= r_mem[a_idx];
            if (b_wr) begin
                r_mem[r_b_idx] <= b_inc;
            end
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_RAW_W)'(0), r_o_max, r_o_min, r_o_val, r_o_idx};

    // checks
    a_clear_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_b_vld && (r_b_cmd == CMD_CLEAR) |=> (r_valid == '0))
        else $error("bin valid flags not cleared");

    a_fwd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_vld |-> r_valid[r_w_idx])
        else $error("forwarded bin not marked valid");

    a_add_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && (r_o_cmd == CMD_ADD) |-> (r_o_val != '0))
        else $error("add request returned zero count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !i_m_tready |=> r_o_vld && $stable(r_o_val) && $stable(r_w_vld))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire
